### hdl/iirc_pkg.sv
// Shared types and constants of the saturating transfer-function controller.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package iirc_pkg;

   localparam int ORDER_DEFAULT     = 3;
   localparam int COEF_FRAC_DEFAULT = 12;

   localparam int DATA_W = 16;   // error, drive and coefficient width
   localparam int PROD_W = 32;   // full 16x16 signed product
   localparam int CSR_AW = 5;    // byte address of seven 32-bit registers
   localparam int CSR_DW = 32;

   // Request kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   // Register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_NUM_COEF0  = 3'd0,
      REG_NUM_COEF1  = 3'd1,
      REG_NUM_COEF2  = 3'd2,
      REG_DEN_COEF1  = 3'd3,
      REG_DEN_COEF2  = 3'd4,
      REG_DRIVE_LOW  = 3'd5,
      REG_DRIVE_HIGH = 3'd6,
      REG_NONE       = 3'd7
   } reg_index_type;

   // Per-cell control, issued by the sequencer in the top level
   typedef struct packed {
      logic clear;      // zero both histories
      logic shift_err;  // take error from the left neighbour
      logic shift_drv;  // take drive from the left neighbour
      logic mul;        // register both tap products
      logic sum;        // pass partial sum to the right
   } cell_ctrl_type;

endpackage

`default_nettype wire

### hdl/iirc_tap_cell.sv
// One tap of the controller chain: error and drive history plus its products.
// Depends on iirc_pkg for widths and the cell control struct.
`default_nettype none

module iirc_tap_cell
   import iirc_pkg::*;
#(
   parameter int ACC_W = PROD_W + ORDER_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cell_ctrl_type            ctrl,
   input  wire logic signed [DATA_W-1:0] err_in,
   input  wire logic signed [DATA_W-1:0] drv_in,
   input  wire logic signed [DATA_W-1:0] num_coef,
   input  wire logic signed [DATA_W-1:0] den_coef,
   input  wire logic signed [ACC_W-1:0]  psum_in,
   output logic signed [DATA_W-1:0]      err_out,
   output logic signed [DATA_W-1:0]      drv_out,
   output logic signed [ACC_W-1:0]       psum_out
);

   logic signed [DATA_W-1:0] err_ff, err_in_d;
   logic signed [DATA_W-1:0] drv_ff, drv_in_d;
   logic signed [PROD_W-1:0] pnum_ff, pnum_in;
   logic signed [PROD_W-1:0] pden_ff, pden_in;
   logic signed [ACC_W-1:0]  psum_ff, psum_in_d;

   always_comb begin
      err_in_d  = err_ff;
      drv_in_d  = drv_ff;
      if (ctrl.clear) begin
         err_in_d = '0;
         drv_in_d = '0;
      end else begin
         if (ctrl.shift_err) err_in_d = err_in;
         if (ctrl.shift_drv) drv_in_d = drv_in;
      end
      pnum_in   = ctrl.mul ? PROD_W'(num_coef * err_ff) : pnum_ff;
      pden_in   = ctrl.mul ? PROD_W'(den_coef * drv_ff) : pden_ff;
      psum_in_d = ctrl.sum ? (psum_in + ACC_W'(pnum_ff) - ACC_W'(pden_ff)) : psum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= '0;
         drv_ff <= '0;
      end else begin
         err_ff <= err_in_d;
         drv_ff <= drv_in_d;
      end
   end

   // Products and partial sums carry no reset
   always_ff @(posedge clock) begin
      pnum_ff <= pnum_in;
      pden_ff <= pden_in;
      psum_ff <= psum_in_d;
   end

   assign err_out  = err_ff;
   assign drv_out  = drv_ff;
   assign psum_out = psum_ff;

endmodule

`default_nettype wire

### hdl/iirc_drive_clamp.sv
// Scales the accumulated sum back to drive units and clamps it to the limits.
// Depends on iirc_pkg for the data width.
`default_nettype none

module iirc_drive_clamp
   import iirc_pkg::*;
#(
   parameter int ACC_W     = PROD_W + ORDER_DEFAULT,
   parameter int FRAC_BITS = COEF_FRAC_DEFAULT
) (
   input  wire logic signed [ACC_W-1:0]  acc,
   input  wire logic signed [DATA_W-1:0] drive_low,
   input  wire logic signed [DATA_W-1:0] drive_high,
   output logic signed [DATA_W-1:0]      drive
);

   logic signed [ACC_W-1:0] scaled;
   logic signed [ACC_W-1:0] low_x;
   logic signed [ACC_W-1:0] high_x;
   logic signed [ACC_W-1:0] limited;

   always_comb begin
      scaled  = acc >>> FRAC_BITS;   // floor towards minus infinity
      low_x   = ACC_W'(drive_low);
      high_x  = ACC_W'(drive_high);
      limited = scaled;
      // upper limit first, lower limit wins when the limits are inverted
      if (limited > high_x) limited = high_x;
      if (limited < low_x)  limited = low_x;
      drive   = limited[DATA_W-1:0];
   end

endmodule

`default_nettype wire

### hdl/iir_controller_saturating.sv
// Top level of the saturating transfer-function controller: register file,
// sequencer, chain of tap cells and output register. Uses iirc_pkg,
// iirc_tap_cell and iirc_drive_clamp.
//
//   channel   direction  handshake           payload
//   req       in         req_valid/req_stall req_kind, req_error_in
//   rsp       out        rsp_valid/rsp_stall rsp_drive_out
//   csr       in/out     psel/penable/pready paddr, pwrite, pwdata, prdata
//
// A control sample passes these steps after acceptance: shift, multiply in
// every cell, let the partial sum ripple down the chain of cells, then
// scale and clamp. A clear request goes straight to its result.
// Reset zeroes both histories and loads
// the reset register values. A stalled result sits in the output register
// while the next request is taken; only the final write waits for it.
`default_nettype none

module iir_controller_saturating
   import iirc_pkg::*;
#(
   parameter int ORDER          = ORDER_DEFAULT,
   parameter int COEF_FRAC_BITS = COEF_FRAC_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_kind,
   input  wire logic signed [DATA_W-1:0] req_error_in,
   // result channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_drive_out,
   // configuration port
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_AW-1:0]        paddr,
   input  wire logic [CSR_DW-1:0]        pwdata,
   output logic [CSR_DW-1:0]             prdata,
   output logic                          pready
);

   localparam int ACC_W = PROD_W + ORDER;          // headroom for 2*ORDER-1 products
   localparam int CNT_W = $clog2(ORDER) + 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_SUM  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic signed [DATA_W-1:0] num0_ff, num1_ff, num2_ff, den1_ff, den2_ff;
   logic signed [DATA_W-1:0] low_ff, high_ff;
   reg_index_type            csr_index;
   logic                     csr_write;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[CSR_AW-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num0_ff <= '0;
         num1_ff <= '0;
         num2_ff <= '0;
         den1_ff <= '0;
         den2_ff <= '0;
         low_ff  <= 16'sh8000;
         high_ff <= 16'sh7FFF;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_NUM_COEF0:  num0_ff <= pwdata[DATA_W-1:0];
            REG_NUM_COEF1:  num1_ff <= pwdata[DATA_W-1:0];
            REG_NUM_COEF2:  num2_ff <= pwdata[DATA_W-1:0];
            REG_DEN_COEF1:  den1_ff <= pwdata[DATA_W-1:0];
            REG_DEN_COEF2:  den2_ff <= pwdata[DATA_W-1:0];
            REG_DRIVE_LOW:  low_ff  <= pwdata[DATA_W-1:0];
            REG_DRIVE_HIGH: high_ff <= pwdata[DATA_W-1:0];
            default: ;      // drop writes beyond the register list
         endcase
      end
   end

   // Read back sign-extended
   always_comb begin
      unique case (csr_index)
         REG_NUM_COEF0:  prdata = CSR_DW'(num0_ff);
         REG_NUM_COEF1:  prdata = CSR_DW'(num1_ff);
         REG_NUM_COEF2:  prdata = CSR_DW'(num2_ff);
         REG_DEN_COEF1:  prdata = CSR_DW'(den1_ff);
         REG_DEN_COEF2:  prdata = CSR_DW'(den2_ff);
         REG_DRIVE_LOW:  prdata = CSR_DW'(low_ff);
         REG_DRIVE_HIGH: prdata = CSR_DW'(high_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             clear_ff, clear_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic             req_accept;
   logic             out_free;
   logic             finish;
   logic signed [DATA_W-1:0] drive_new;
   logic             do_clear, do_shift, do_mul, do_sum, do_load;

   // The histories are busy until the current request has written its drive
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign finish     = (state_ff == ST_DONE) && out_free;

   assign do_clear = req_accept && (req_kind == KIND_CLEAR);
   assign do_shift = req_accept && (req_kind == KIND_SAMPLE);
   assign do_mul   = (state_ff == ST_MUL);
   assign do_sum   = (state_ff == ST_SUM);
   assign do_load  = finish && !clear_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      clear_in = clear_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               clear_in = (req_kind == KIND_CLEAR);
               state_in = (req_kind == KIND_CLEAR) ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            cnt_in   = '0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // advance the partial sum one cell per cycle
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ORDER - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;   // hold while the result waits
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_drive_in = clear_ff ? '0 : drive_new;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         clear_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_out = rsp_drive_ff;

   // ---------------------------------------------------------------------
   // Chain of tap cells: cell k holds e[k] and u[k]
   // ---------------------------------------------------------------------
   logic signed [DATA_W-1:0] err_link  [ORDER];
   logic signed [DATA_W-1:0] drv_link  [ORDER];
   logic signed [ACC_W-1:0]  psum_link [ORDER];

   for (genvar k = 0; k < ORDER; k++) begin : g_cell
      cell_ctrl_type            ctrl;
      logic signed [DATA_W-1:0] e_src, u_src, n_coef, d_coef;
      logic signed [ACC_W-1:0]  p_src;

      if (k == 0) begin : g_head
         // newest error enters here; the newest drive arrives at the end
         assign e_src  = req_error_in;
         assign u_src  = drive_new;
         assign p_src  = '0;
         assign n_coef = num0_ff;
         assign d_coef = '0;   // newest drive takes no part in its own sum
         assign ctrl   = '{clear: do_clear, shift_err: do_shift, shift_drv: do_load,
                           mul: do_mul, sum: do_sum};
      end else begin : g_tail
         assign e_src  = err_link[k-1];
         assign u_src  = drv_link[k-1];
         assign p_src  = psum_link[k-1];
         assign n_coef = (k == 1) ? num1_ff : num2_ff;
         assign d_coef = (k == 1) ? den1_ff : den2_ff;
         assign ctrl   = '{clear: do_clear, shift_err: do_shift, shift_drv: do_shift,
                           mul: do_mul, sum: do_sum};
      end

      iirc_tap_cell #(
         .ACC_W (ACC_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .err_in   (e_src),
         .drv_in   (u_src),
         .num_coef (n_coef),
         .den_coef (d_coef),
         .psum_in  (p_src),
         .err_out  (err_link[k]),
         .drv_out  (drv_link[k]),
         .psum_out (psum_link[k])
      );
   end

   // ---------------------------------------------------------------------
   // Scale and clamp the sum leaving the last cell
   // ---------------------------------------------------------------------
   iirc_drive_clamp #(
      .ACC_W     (ACC_W),
      .FRAC_BITS (COEF_FRAC_BITS)
   ) u_clamp (
      .acc        (psum_link[ORDER-1]),
      .drive_low  (low_ff),
      .drive_high (high_ff),
      .drive      (drive_new)
   );

endmodule

`default_nettype wire
